// File: rtl/core/sqtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtd_pkg
// shared types, sizes and codes of the shortest queue teller dispatcher
// ----------------------------------------------------------------------------
package sqtd_pkg;

    localparam int NUM_SERVERS = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 8;

    localparam int SRV_W   = $clog2(NUM_SERVERS);
    localparam int ACT_W   = $clog2(NUM_SERVERS + 1);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NUM_SERVERS * QUEUE_DEPTH);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int TAG_W   = 16;
    localparam int STIME_W = 16;
    localparam int ENTRY_W = TAG_W + STIME_W;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_ARRIVE = 2'd1,
        MODE_CLOSE  = 2'd2,
        MODE_OPEN   = 2'd3
    } mode_t;

    localparam logic KIND_DEPART = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] customer_tag;
        logic [15:0] service_time;
        logic [2:0]  server_index;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] tag_out;
        logic [2:0]  server_out;
        logic [31:0] time_stamp;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TK_CHECK,
        ST_TK_WAIT,
        ST_TK_HEAD,
        ST_TK_WAIT2,
        ST_TK_LOAD,
        ST_CL_READ,
        ST_CL_WAIT,
        ST_CL_GOT,
        ST_SCAN,
        ST_ENQ,
        ST_FINISH
    } state_t;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [SRV_W-1:0] srv,
                                                     input logic [PTR_W-1:0] ptr);
        entry_addr = ADDR_W'(int'(srv) * QUEUE_DEPTH + int'(ptr));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (int'(ptr) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(ptr) + 1);
    endfunction

endpackage

// File: rtl/core/sqtd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtd_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sqtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/shortest_queue_teller_dispatcher.sv
`timescale 1ns / 1ps
// timing: an arrival scans each active server and then enqueues, a tick visits
// each active server and loads the next head on a departure, a close reads and
// rescans for each moved entry; results leave through one output register, one
// beat per cycle when the sink keeps m_ready high; one item at a time, and the
// serial server scan and the single ram read port set the pace
// reset: synchronous active low; all servers open, queues empty, tick count 0
// ----------------------------------------------------------------------------
// shortest_queue_teller_dispatcher
// join-shortest-queue dispatcher over per-server fifos with tick, close, open
// ----------------------------------------------------------------------------
module shortest_queue_teller_dispatcher
    import sqtd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [3:0] cfg_data
);

    // control state
    state_t state_reg, state_next;
    logic [3:0] active_servers_reg, active_servers_next;
    logic [ACT_W-1:0] act_reg, act_next;              // effective active count
    logic [ACT_W-1:0] idx_reg, idx_next;              // server loop / scan counter
    logic [1:0] mode_reg, mode_next;
    logic [SRV_W-1:0] sel_reg, sel_next;              // server being closed
    logic [QCNT_W-1:0] moves_reg, moves_next;         // entries still to move
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [SRV_W-1:0] best_reg, best_next;
    logic [QCNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic found_reg, found_next;
    logic [31:0] tick_reg, tick_next;

    // per-server state
    logic server_open_reg [NUM_SERVERS];
    logic server_open_next [NUM_SERVERS];
    logic [QCNT_W-1:0] qcount_reg [NUM_SERVERS];
    logic [QCNT_W-1:0] qcount_next [NUM_SERVERS];
    logic [STIME_W-1:0] tleft_reg [NUM_SERVERS];
    logic [STIME_W-1:0] tleft_next [NUM_SERVERS];
    logic [PTR_W-1:0] head_reg [NUM_SERVERS];
    logic [PTR_W-1:0] head_next [NUM_SERVERS];
    logic [PTR_W-1:0] tail_reg [NUM_SERVERS];
    logic [PTR_W-1:0] tail_next [NUM_SERVERS];

    // result staging: a pending beat waits until we know whether it is the last
    out_item_t pend_reg;
    logic pend_valid_reg;
    out_item_t out_reg;
    logic out_valid_reg;
    logic [RES_W-1:0] res_cnt_reg;

    // emit request from the sequencer
    logic emit_req, flush_req, emit_kind, stall, can_out, emit_ok;
    logic [TAG_W-1:0] emit_tag;
    logic [SRV_W-1:0] emit_srv;
    logic load_out;
    out_item_t flush_beat;

    // ram
    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [SRV_W-1:0] cur;
    logic [STIME_W-1:0] tl_dec;
    logic [ACT_W-1:0] act_eff;

    assign cur = idx_reg[SRV_W-1:0];
    assign tl_dec = (tleft_reg[cur] != '0) ? tleft_reg[cur] - 1'b1 : '0;

    // zero acts as one, anything above the server count is clamped
    always_comb begin
        if (active_servers_reg == 4'd0) begin
            act_eff = ACT_W'(1);
        end else if (int'(active_servers_reg) > NUM_SERVERS) begin
            act_eff = ACT_W'(NUM_SERVERS);
        end else begin
            act_eff = ACT_W'(active_servers_reg);
        end
    end

    assign can_out = !out_valid_reg || m_ready;
    assign emit_ok = int'(res_cnt_reg) < MAX_RESULTS;
    // a new beat needs the pending slot freed into the output register
    assign stall = (emit_req && emit_ok && pend_valid_reg && !can_out) ||
                   (flush_req && pend_valid_reg && !can_out);
    // pending beat moves into the output register this cycle
    assign load_out = !stall && pend_valid_reg && ((emit_req && emit_ok) || flush_req);
    // pending beat marked as the final one of the item
    assign flush_beat = {pend_reg[$bits(out_item_t)-1:1], 1'b1};

    sqtd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_SERVERS * QUEUE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(entry_reg),
        .raddr(rd_addr_reg),
        .rdata(ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        if (!stall) begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        priority if (s_data.mode == MODE_TICK) begin
                            state_next = ST_TK_CHECK;
                        end else if (s_data.mode == MODE_ARRIVE) begin
                            state_next = ST_SCAN;
                        end else if (s_data.mode == MODE_CLOSE &&
                                     ACT_W'(s_data.server_index) < act_eff &&
                                     qcount_reg[SRV_W'(s_data.server_index)] >= QCNT_W'(2)) begin
                            state_next = ST_CL_READ;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end
                ST_TK_CHECK: begin
                    if (idx_reg == act_reg) begin
                        state_next = ST_FINISH;
                    end else if (qcount_reg[cur] != '0 && tl_dec == '0) begin
                        state_next = ST_TK_WAIT;
                    end
                end
                ST_TK_WAIT:  state_next = ST_TK_HEAD;
                ST_TK_HEAD: begin
                    state_next = (qcount_reg[cur] != QCNT_W'(1)) ? ST_TK_WAIT2 : ST_TK_CHECK;
                end
                ST_TK_WAIT2: state_next = ST_TK_LOAD;
                ST_TK_LOAD:  state_next = ST_TK_CHECK;
                ST_CL_READ:  state_next = ST_CL_WAIT;
                ST_CL_WAIT:  state_next = ST_CL_GOT;
                ST_CL_GOT:   state_next = ST_SCAN;
                ST_SCAN: begin
                    if (idx_reg == act_reg) begin
                        state_next = ST_ENQ;
                    end
                end
                ST_ENQ: begin
                    state_next = (mode_reg == MODE_CLOSE && moves_reg != '0) ?
                                 ST_CL_READ : ST_FINISH;
                end
                ST_FINISH:   state_next = ST_IDLE;
                default:     state_next = ST_IDLE;
            endcase
        end
    end

    // sequencer outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        emit_req  = 1'b0;
        flush_req = 1'b0;
        emit_kind = KIND_DEPART;
        emit_tag  = ram_rdata[ENTRY_W-1 -: TAG_W];
        emit_srv  = cur;
        unique case (state_reg)
            ST_TK_HEAD: begin
                emit_req = 1'b1;
            end
            ST_ENQ: begin
                emit_req  = (qcount_reg[best_reg] >= QCNT_W'(QUEUE_DEPTH));
                emit_kind = KIND_REJECT;
                emit_tag  = entry_reg[ENTRY_W-1 -: TAG_W];
                emit_srv  = best_reg;
            end
            ST_FINISH: begin
                flush_req = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        active_servers_next = active_servers_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        mode_next     = mode_reg;
        sel_next      = sel_reg;
        moves_next    = moves_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_addr_next  = rd_addr_reg;
        entry_next    = entry_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        found_next    = found_reg;
        tick_next     = tick_reg;
        server_open_next = server_open_reg;
        qcount_next   = qcount_reg;
        tleft_next    = tleft_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ram_we        = 1'b0;
        ram_waddr     = entry_addr(best_reg, tail_reg[best_reg]);

        if (cfg_valid) begin
            active_servers_next = cfg_data;
        end

        if (!stall) begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_next   = act_eff;
                        mode_next  = s_data.mode;
                        idx_next   = '0;
                        best_next  = '0;
                        found_next = 1'b0;
                        sel_next   = SRV_W'(s_data.server_index);
                        entry_next = {s_data.customer_tag, s_data.service_time};
                        if (s_data.mode == MODE_TICK) begin
                            tick_next = tick_reg + 32'd1;
                        end else if (s_data.mode != MODE_ARRIVE &&
                                     ACT_W'(s_data.server_index) < act_eff) begin
                            server_open_next[SRV_W'(s_data.server_index)] =
                                (s_data.mode == MODE_OPEN);
                            // close keeps the head and pulls out the rest
                            if (s_data.mode == MODE_CLOSE &&
                                qcount_reg[SRV_W'(s_data.server_index)] >= QCNT_W'(2)) begin
                                moves_next = qcount_reg[SRV_W'(s_data.server_index)] - 1'b1;
                                qcount_next[SRV_W'(s_data.server_index)] = QCNT_W'(1);
                                rd_ptr_next = ptr_inc(head_reg[SRV_W'(s_data.server_index)]);
                                tail_next[SRV_W'(s_data.server_index)] =
                                    ptr_inc(head_reg[SRV_W'(s_data.server_index)]);
                            end
                        end
                    end
                end
                ST_TK_CHECK: begin
                    if (idx_reg != act_reg) begin
                        if (qcount_reg[cur] == '0) begin
                            idx_next = idx_reg + 1'b1;
                        end else begin
                            tleft_next[cur] = tl_dec;
                            if (tl_dec == '0) begin
                                rd_addr_next = entry_addr(cur, head_reg[cur]);
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_TK_HEAD: begin
                    head_next[cur]   = ptr_inc(head_reg[cur]);
                    qcount_next[cur] = qcount_reg[cur] - 1'b1;
                    if (qcount_reg[cur] != QCNT_W'(1)) begin
                        rd_addr_next = entry_addr(cur, ptr_inc(head_reg[cur]));
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                ST_TK_LOAD: begin
                    tleft_next[cur] = ram_rdata[STIME_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                ST_CL_READ: begin
                    rd_addr_next = entry_addr(sel_reg, rd_ptr_reg);
                end
                ST_CL_GOT: begin
                    entry_next  = ram_rdata;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    moves_next  = moves_reg - 1'b1;
                    idx_next    = '0;
                    best_next   = '0;
                    found_next  = 1'b0;
                end
                ST_SCAN: begin
                    if (idx_reg != act_reg) begin
                        if (server_open_reg[cur] &&
                            (!found_reg || qcount_reg[cur] < best_cnt_reg)) begin
                            best_next     = cur;
                            best_cnt_next = qcount_reg[cur];
                            found_next    = 1'b1;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                end
                ST_ENQ: begin
                    if (qcount_reg[best_reg] < QCNT_W'(QUEUE_DEPTH)) begin
                        ram_we = 1'b1;
                        tail_next[best_reg] = ptr_inc(tail_reg[best_reg]);
                        if (qcount_reg[best_reg] == '0) begin
                            tleft_next[best_reg] = entry_reg[STIME_W-1:0];
                        end
                        qcount_next[best_reg] = qcount_reg[best_reg] + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            active_servers_reg <= 4'(NUM_SERVERS);
            tick_reg           <= '0;
            idx_reg            <= '0;
            for (int i = 0; i < NUM_SERVERS; i++) begin
                server_open_reg[i] <= 1'b1;
                qcount_reg[i]      <= '0;
                tleft_reg[i]       <= '0;
                head_reg[i]        <= '0;
                tail_reg[i]        <= '0;
            end
        end else begin
            state_reg          <= state_next;
            active_servers_reg <= active_servers_next;
            tick_reg           <= tick_next;
            idx_reg            <= idx_next;
            server_open_reg    <= server_open_next;
            qcount_reg         <= qcount_next;
            tleft_reg          <= tleft_next;
            head_reg           <= head_next;
            tail_reg           <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        mode_reg     <= mode_next;
        sel_reg      <= sel_next;
        moves_reg    <= moves_next;
        rd_ptr_reg   <= rd_ptr_next;
        rd_addr_reg  <= rd_addr_next;
        entry_reg    <= entry_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        found_reg    <= found_next;
    end

    // result staging: pending beat moves out when a newer one arrives
    // (last clear) or when the item finishes (last set)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_cnt_reg    <= '0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE) begin
                res_cnt_reg <= '0;
            end
            if (!stall && emit_req && emit_ok) begin
                if (pend_valid_reg) begin
                    out_reg <= pend_reg;
                end
                pend_reg.kind       <= emit_kind;
                pend_reg.tag_out    <= emit_tag;
                pend_reg.server_out <= 3'(emit_srv);
                pend_reg.time_stamp <= tick_reg;
                pend_reg.last       <= 1'b0;
                pend_valid_reg      <= 1'b1;
                res_cnt_reg         <= res_cnt_reg + 1'b1;
            end
            if (!stall && flush_req && pend_valid_reg) begin
                out_reg        <= flush_beat;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: rtl/core/sqtd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtd_port_props
// port-level checks of the dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module sqtd_port_props
    import sqtd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // result beat holds until taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before accept");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    // one item at a time: an accepted beat closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while busy");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind shortest_queue_teller_dispatcher sqtd_port_props u_sqtd_port_props (.*);

// File: verif/sqtd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtd_checker
// watches the item, result and register channels of the dispatcher, keeps a
// model of the queues, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module sqtd_checker
    import sqtd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output int         error_count,
    output int         pending_count,
    output int         result_count
);

    logic [3:0]  act_reg;
    logic        srv_open [NUM_SERVERS];
    int unsigned q_cnt    [NUM_SERVERS];
    logic [15:0] t_left   [NUM_SERVERS];
    logic [31:0] q_mem    [NUM_SERVERS][QUEUE_DEPTH];
    int unsigned hd       [NUM_SERVERS];
    int unsigned tl       [NUM_SERVERS];
    logic [31:0] ticks;

    out_item_t beats_due[$];
    out_item_t step_buf[$];

    function automatic int unsigned eff_active();
        int unsigned a;
        a = act_reg;
        if (a == 0) a = 1;
        if (a > NUM_SERVERS) a = NUM_SERVERS;
        return a;
    endfunction

    function automatic void push_result(logic kind, logic [15:0] tag, int unsigned srv);
        out_item_t r;
        if (step_buf.size() >= MAX_RESULTS) return;
        r.kind = kind;
        r.tag_out = tag;
        r.server_out = srv[2:0];
        r.time_stamp = ticks;
        r.last = 1'b0;
        step_buf.push_back(r);
    endfunction

    function automatic int unsigned pick_server();
        int unsigned best, best_cnt;
        best = 0;
        best_cnt = 32'hFFFF_FFFF;
        for (int unsigned i = 0; i < eff_active(); i++) begin
            if (srv_open[i] && q_cnt[i] < best_cnt) begin
                best = i;
                best_cnt = q_cnt[i];
            end
        end
        return best;
    endfunction

    function automatic void join_queue(logic [31:0] ent);
        int unsigned s;
        s = pick_server();
        if (q_cnt[s] >= QUEUE_DEPTH) begin
            push_result(KIND_REJECT, ent[31:16], s);
            return;
        end
        q_mem[s][tl[s]] = ent;
        tl[s] = (tl[s] + 1) % QUEUE_DEPTH;
        if (q_cnt[s] == 0) t_left[s] = ent[15:0];
        q_cnt[s]++;
    endfunction

    function automatic void serve_tick();
        ticks++;
        for (int unsigned i = 0; i < eff_active(); i++) begin
            if (q_cnt[i] == 0) continue;
            if (t_left[i] != 0) t_left[i]--;
            if (t_left[i] == 0) begin
                push_result(KIND_DEPART, q_mem[i][hd[i]][31:16], i);
                hd[i] = (hd[i] + 1) % QUEUE_DEPTH;
                q_cnt[i]--;
                if (q_cnt[i] != 0) t_left[i] = q_mem[i][hd[i]][15:0];
            end
        end
    endfunction

    function automatic void close_server(int unsigned s);
        logic [31:0] moved[$];
        int unsigned k;
        srv_open[s] = 1'b0;
        if (q_cnt[s] < 2) return;
        k = q_cnt[s] - 1;
        for (int unsigned j = 0; j < k; j++)
            moved.push_back(q_mem[s][(hd[s] + 1 + j) % QUEUE_DEPTH]);
        q_cnt[s] = 1;
        tl[s] = (hd[s] + 1) % QUEUE_DEPTH;
        foreach (moved[j]) join_queue(moved[j]);
    endfunction

    function automatic void predict_item(in_item_t it);
        step_buf.delete();
        case (it.mode)
            MODE_TICK:   serve_tick();
            MODE_ARRIVE: join_queue({it.customer_tag, it.service_time});
            default: begin
                if (it.server_index < eff_active()) begin
                    if (it.mode == MODE_CLOSE) close_server(it.server_index);
                    else srv_open[it.server_index] = 1'b1;
                end
            end
        endcase
        if (step_buf.size() > 0) step_buf[step_buf.size()-1].last = 1'b1;
        foreach (step_buf[i]) beats_due.push_back(step_buf[i]);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
        error_count++;
    endtask

    assign pending_count = beats_due.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 4'd8;
            ticks = '0;
            error_count = 0;
            result_count = 0;
            for (int i = 0; i < NUM_SERVERS; i++) begin
                srv_open[i] = 1'b1;
                q_cnt[i] = 0;
                t_left[i] = '0;
                hd[i] = 0;
                tl[i] = 0;
            end
            beats_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) act_reg <= cfg_data;
            if (m_valid && m_ready) begin
                out_item_t w;
                result_count++;
                if (beats_due.size() == 0) begin
                    report_mismatch("unexpected beat", m_data, 0);
                end else begin
                    w = beats_due.pop_front();
                    if (m_data.kind !== w.kind) report_mismatch("kind", m_data.kind, w.kind);
                    if (m_data.tag_out !== w.tag_out)
                        report_mismatch("tag_out", m_data.tag_out, w.tag_out);
                    if (m_data.server_out !== w.server_out)
                        report_mismatch("server_out", m_data.server_out, w.server_out);
                    if (m_data.time_stamp !== w.time_stamp)
                        report_mismatch("time_stamp", m_data.time_stamp, w.time_stamp);
                    if (m_data.last !== w.last) report_mismatch("last", m_data.last, w.last);
                end
            end
            if (s_valid && s_ready) predict_item(s_data);
        end
    end

endmodule

// File: verif/shortest_queue_teller_dispatcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_teller_dispatcher_tb
// drives arrivals, ticks, closes and opens through several server counts with
// random stalls on both channels; a checker module predicts and compares
// ----------------------------------------------------------------------------
module shortest_queue_teller_dispatcher_tb;
    import sqtd_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;
    int         error_count;
    int         pending_count;
    int         result_count;

    // stall percentages, changed in phases 2 and 4
    int         src_idle_pct;
    int         snk_idle_pct;
    int         items_sent;

    shortest_queue_teller_dispatcher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sqtd_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sink stalls at random, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // one item beat; optional idle cycles first, valid held until accepted
    task automatic send_item(logic [1:0] md, logic [15:0] tg, logic [15:0] st,
                             logic [2:0] ix);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{mode: md, customer_tag: tg, service_time: st, server_index: ix};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // drain outstanding beats, let the block settle, then write the register
    task automatic set_active(logic [3:0] val);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        // items with no result may still be in flight; wait out a long close
        repeat (400) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly arrivals and ticks with short service times so queues fill and drain
    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_item(MODE_ARRIVE, 16'($urandom()),
                      ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(4)),
                      3'($urandom()));
        else if (r < 80)
            send_item(MODE_TICK, 16'($urandom()), 16'($urandom()), 3'($urandom()));
        else if (r < 90)
            send_item(MODE_CLOSE, 16'($urandom()), 16'($urandom()), 3'($urandom()));
        else
            send_item(MODE_OPEN, 16'($urandom()), 16'($urandom()), 3'($urandom()));
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 4'd8;
        src_idle_pct = 14;
        snk_idle_pct = 84;
        items_sent   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: two servers, fill one queue, overflow, extremes of tags and times
        set_active(4'd2);
        send_item(MODE_ARRIVE, 16'hFFFF, 16'd0, 3'd7);
        send_item(MODE_ARRIVE, 16'h0000, 16'hFFFF, 3'd0);
        send_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 3'd7);
        send_item(MODE_CLOSE, 16'd0, 16'd0, 3'd5);      // index out of range
        send_item(MODE_CLOSE, 16'd0, 16'd0, 3'd1);
        // only server 0 open: fill it past depth for rejections
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_item(MODE_ARRIVE, 16'(16'hA500 + i), 16'd1, 3'd0);
        // close server 0 with no server open: entries come back behind the head
        send_item(MODE_CLOSE, 16'd0, 16'd0, 3'd0);
        send_item(MODE_CLOSE, 16'd0, 16'd0, 3'd0);      // close of a closed server
        send_item(MODE_OPEN, 16'd0, 16'd0, 3'd1);
        send_item(MODE_OPEN, 16'd0, 16'd0, 3'd0);

        // random phases across counts, idling pattern swaps then stops
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_active(4'd8);
                1: set_active(4'd0);
                2: set_active(4'd15);
                3: set_active(4'd1);
                4: set_active(4'd3);
                default: set_active(4'd8);
            endcase
            if (ph == 2) begin
                src_idle_pct = 84;
                snk_idle_pct = 14;
            end else if (ph == 4) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            for (int i = 0; i < 11; i++) random_item();
        end
        // drain the queues with ticks
        for (int i = 0; i < 12; i++) send_item(MODE_TICK, 16'd0, 16'd0, 3'd0);
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("covered %0d items and %0d result beats over server counts 0 to 15",
                 items_sent, result_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("shortest_queue_teller_dispatcher_tb: done, clean");
        end else begin
            $display("shortest_queue_teller_dispatcher_tb: done, errors");
        end
        $finish;
    end

    // generous limit for the slowest legal run
    initial begin
        #20ms;
        $display("timeout");
        $display("shortest_queue_teller_dispatcher_tb: done, errors");
        $finish;
    end

endmodule

// File: shortest_queue_teller_dispatcher.f
rtl/core/sqtd_pkg.sv
rtl/core/sqtd_ram.sv
rtl/core/shortest_queue_teller_dispatcher.sv
rtl/core/sqtd_checker.sv
verif/sqtd_checker.sv
verif/shortest_queue_teller_dispatcher_tb.sv
